// ===== sv/refcounted_lru_tag_cache_core_assert.svh =====
// assertion macros for the tag cache directory
`ifndef REFCOUNTED_LRU_TAG_CACHE_CORE_ASSERT_SVH
`define REFCOUNTED_LRU_TAG_CACHE_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RLC_ASSERT_IMPL(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("tag cache assertion failed");

// antecedent implies consequent in the next cycle
`define RLC_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("tag cache assertion failed");

`endif

// ===== sv/rlc_pkg.sv =====
// shared types and codes of the tag cache directory
`timescale 1ns / 1ps
package rlc_pkg;

    localparam logic [2:0] ACT_ACQUIRE   = 3'd0;
    localparam logic [2:0] ACT_RELEASE   = 3'd1;
    localparam logic [2:0] ACT_WRITEBACK = 3'd2;
    localparam logic [2:0] ACT_INVAL     = 3'd3;
    localparam logic [2:0] ACT_LOADFAIL  = 3'd4;
    localparam logic [2:0] ACT_MARK      = 3'd5;

    localparam logic [3:0] ST_HIT       = 4'd0;
    localparam logic [3:0] ST_MISS_READ = 4'd1;
    localparam logic [3:0] ST_MISS_ZERO = 4'd2;
    localparam logic [3:0] ST_DISABLED  = 4'd3;
    localparam logic [3:0] ST_FULL      = 4'd4;
    localparam logic [3:0] ST_BUSY      = 4'd5;
    localparam logic [3:0] ST_LOADFAIL  = 4'd6;
    localparam logic [3:0] ST_RELEASED  = 4'd7;
    localparam logic [3:0] ST_WRITEBACK = 4'd8;
    localparam logic [3:0] ST_INVAL     = 4'd9;
    localparam logic [3:0] ST_FAULT     = 4'd10;
    localparam logic [3:0] ST_MARKED    = 4'd11;

    localparam logic [7:0] REFS_MAX = 8'hFF;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] user_id;
        logic [7:0]  mount_id;
        logic [3:0]  slot;
        logic        force_req;
        logic        quota_enabled;
        logic        quota_file_open;
        logic        record_in_file;
    } req_t;

    typedef struct packed {
        logic [3:0] status;
        logic [3:0] result_slot;
        logic       wake_waiters;
    } rsp_t;

    typedef enum logic [3:0] {
        SOP_NONE,
        SOP_SET_WANT,
        SOP_HIT,
        SOP_ALLOC,
        SOP_RELEASE,
        SOP_WRITEBACK,
        SOP_INVAL,
        SOP_LOADFAIL,
        SOP_MARK
    } slot_op_t;

    typedef struct packed {
        slot_op_t    op;
        logic [15:0] user_id;
        logic [7:0]  mount_id;
    } slot_cmd_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] refs;
        logic       locked;
        logic       want;
        logic       modified;
    } slot_flags_t;

    typedef enum logic [1:0] {
        FOP_NONE,
        FOP_REMOVE,
        FOP_INS_HEAD,
        FOP_INS_TAIL
    } free_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_EXEC,
        S_FREM,
        S_FINS,
        S_RESP
    } state_t;

endpackage

// ===== sv/rlc_slot_cell.sv =====
// one directory slot: tag, count and flags, with its own tag compare
`timescale 1ns / 1ps
module rlc_slot_cell #(
    parameter int IDX = 0,
    parameter int IW  = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [15:0]         key_user,
    input  logic [7:0]          key_mount,
    input  logic [IW-1:0]       target,
    input  rlc_pkg::slot_cmd_t  cmd,
    output logic                match,
    output rlc_pkg::slot_flags_t flags
);

    logic        valid_reg, valid_next;
    logic [7:0]  refs_reg, refs_next;
    logic        locked_reg, locked_next;
    logic        want_reg, want_next;
    logic        mod_reg, mod_next;
    logic [15:0] user_reg, user_next;
    logic [7:0]  mount_reg, mount_next;
    logic        sel;

    assign sel   = (target == IW'(IDX));
    assign match = valid_reg && (user_reg == key_user) && (mount_reg == key_mount);

    always_comb
    begin
        flags = '0;
        if (sel)
        begin
            flags.valid    = valid_reg;
            flags.refs     = refs_reg;
            flags.locked   = locked_reg;
            flags.want     = want_reg;
            flags.modified = mod_reg;
        end
    end

    always_comb
    begin
        valid_next  = valid_reg;
        refs_next   = refs_reg;
        locked_next = locked_reg;
        want_next   = want_reg;
        mod_next    = mod_reg;
        user_next   = user_reg;
        mount_next  = mount_reg;
        if (sel)
        begin
            unique case (cmd.op)
                rlc_pkg::SOP_SET_WANT:  want_next = 1'b1;
                rlc_pkg::SOP_HIT:
                begin
                    locked_next = 1'b1;
                    refs_next   = refs_reg + 8'd1;
                end
                rlc_pkg::SOP_ALLOC:
                begin
                    valid_next  = 1'b1;
                    user_next   = cmd.user_id;
                    mount_next  = cmd.mount_id;
                    locked_next = 1'b1;
                    refs_next   = 8'd1;
                end
                rlc_pkg::SOP_RELEASE:
                begin
                    locked_next = 1'b0;
                    want_next   = 1'b0;
                    refs_next   = refs_reg - 8'd1;
                    if (refs_reg == 8'd1)
                    begin
                        mod_next = 1'b0;
                    end
                end
                rlc_pkg::SOP_WRITEBACK: mod_next = 1'b0;
                rlc_pkg::SOP_INVAL:
                begin
                    locked_next = 1'b0;
                    valid_next  = 1'b0;
                end
                rlc_pkg::SOP_LOADFAIL:
                begin
                    valid_next  = 1'b0;
                    refs_next   = 8'd0;
                    mod_next    = 1'b0;
                    locked_next = 1'b0;
                    want_next   = 1'b0;
                end
                rlc_pkg::SOP_MARK:      mod_next = 1'b1;
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            refs_reg   <= 8'd0;
            locked_reg <= 1'b0;
            want_reg   <= 1'b0;
            mod_reg    <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            refs_reg   <= refs_next;
            locked_reg <= locked_next;
            want_reg   <= want_next;
            mod_reg    <= mod_next;
        end
    end

    always_ff @(posedge clk)
    begin
        user_reg  <= user_next;
        mount_reg <= mount_next;
    end

endmodule

// ===== sv/rlc_free_cell.sv =====
// one position of the free order, shifting to and from its neighbors
`timescale 1ns / 1ps
module rlc_free_cell #(
    parameter int IDX = 0,
    parameter int N   = 16,
    parameter int IW  = 4,
    parameter int CW  = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rlc_pkg::free_op_t op,
    input  logic [IW-1:0]     s,
    input  logic [CW-1:0]     count,
    input  logic [IW-1:0]     left_val,
    input  logic [IW-1:0]     right_val,
    input  logic              seen_in,
    output logic              seen_out,
    output logic [IW-1:0]     value
);

    logic [IW-1:0] val_reg, val_next;
    logic          occ;

    assign occ      = (CW'(IDX) < count);
    assign seen_out = seen_in || (occ && (val_reg == s));
    assign value    = val_reg;

    always_comb
    begin
        val_next = val_reg;
        unique case (op)
            rlc_pkg::FOP_REMOVE:
            begin
                if (seen_out && ((CW + 1)'(IDX + 1) < {1'b0, count}))
                begin
                    val_next = right_val;
                end
            end
            rlc_pkg::FOP_INS_HEAD: val_next = left_val;
            rlc_pkg::FOP_INS_TAIL:
            begin
                if (CW'(IDX) == count)
                begin
                    val_next = s;
                end
            end
            default:               ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= IW'(N - 1 - IDX);
        end
        else
        begin
            val_reg <= val_next;
        end
    end

endmodule

// ===== sv/refcounted_lru_tag_cache_core.sv =====
// top level of the reference-counted lru tag cache directory
`timescale 1ns / 1ps
`include "refcounted_lru_tag_cache_core_assert.svh"
// After acceptance a request passes through these steps before its response is
// presented: associative tag compare across the row of slot cells, decide and
// update the addressed slot, then unlink the slot from the free order chain and
// relink it at the head or tail when the action moves it. One request is in
// flight at a time; req_stall is high from acceptance until the response
// transaction completes, so the block takes no new request before the response
// to the last one is taken. Response stalls keep the block busy for longer.
module refcounted_lru_tag_cache_core #(
    parameter int NUM_ENTRIES = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  rlc_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output rlc_pkg::rsp_t rsp
);

    localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CW = $clog2(NUM_ENTRIES + 1);
    localparam int TW = (IW > 4) ? IW : 4;

    rlc_pkg::state_t    state_reg, state_next;
    rlc_pkg::req_t      req_reg;
    logic               hit_reg;
    logic [IW-1:0]      hit_idx_reg;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [IW-1:0]      fs_reg;
    logic               rem_reg;
    rlc_pkg::free_op_t  ins_reg;
    rlc_pkg::rsp_t      rsp_reg;

    logic [NUM_ENTRIES-1:0]   match;
    logic [NUM_ENTRIES:0]     hit_before;
    rlc_pkg::slot_flags_t     cell_flags [NUM_ENTRIES];
    rlc_pkg::slot_flags_t     fl;
    logic                     any_hit;
    logic [IW-1:0]            first_idx;

    logic [IW-1:0]            fval [NUM_ENTRIES];
    logic [NUM_ENTRIES:0]     seen;
    rlc_pkg::free_op_t        fop;

    logic [TW:0]              slot_w;
    logic                     slot_ok;
    logic [IW-1:0]            slot_ix;
    logic [IW-1:0]            tgt;
    logic [TW-1:0]            tgt_w;
    rlc_pkg::slot_cmd_t       cmd;
    rlc_pkg::slot_op_t        dec_op;
    logic [3:0]               dec_status;
    logic [3:0]               dec_rs;
    logic                     dec_wake;
    logic                     dec_rem;
    rlc_pkg::free_op_t        dec_ins;
    logic                     req_acc;

    assign req_acc = req_valid && !req_stall;
    assign slot_w  = (TW + 1)'(req_reg.slot);
    assign slot_ok = slot_w < (TW + 1)'(NUM_ENTRIES);
    assign slot_ix = slot_w[IW-1:0];

    assign hit_before[0] = 1'b0;
    assign seen[0]       = 1'b0;

    for (genvar i = 0; i < NUM_ENTRIES; i++)
    begin : g_cell
        rlc_slot_cell #(.IDX(i), .IW(IW)) u_slot (
            .clk       (clk),
            .rst_n     (rst_n),
            .key_user  (req_reg.user_id),
            .key_mount (req_reg.mount_id),
            .target    (tgt),
            .cmd       (cmd),
            .match     (match[i]),
            .flags     (cell_flags[i])
        );
        assign hit_before[i+1] = hit_before[i] || match[i];

        rlc_free_cell #(.IDX(i), .N(NUM_ENTRIES), .IW(IW), .CW(CW)) u_free (
            .clk       (clk),
            .rst_n     (rst_n),
            .op        (fop),
            .s         (fs_reg),
            .count     (cnt_reg),
            .left_val  ((i == 0) ? fs_reg : fval[(i == 0) ? 0 : i - 1]),
            .right_val (fval[(i == NUM_ENTRIES - 1) ? i : i + 1]),
            .seen_in   (seen[i]),
            .seen_out  (seen[i+1]),
            .value     (fval[i])
        );
    end

    assign any_hit = hit_before[NUM_ENTRIES];

    always_comb
    begin
        first_idx = '0;
        fl        = '0;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (match[i] && !hit_before[i])
            begin
                first_idx = first_idx | IW'(i);
            end
            fl = fl | cell_flags[i];
        end
    end

    // target slot of the executing request
    always_comb
    begin
        if (req_reg.action == rlc_pkg::ACT_ACQUIRE)
        begin
            tgt = hit_reg ? hit_idx_reg : fval[0];
        end
        else
        begin
            tgt = slot_ix;
        end
    end

    assign tgt_w = TW'(tgt);

    always_comb
    begin
        dec_op     = rlc_pkg::SOP_NONE;
        dec_status = rlc_pkg::ST_FAULT;
        dec_rs     = req_reg.slot;
        dec_wake   = 1'b0;
        dec_rem    = 1'b0;
        dec_ins    = rlc_pkg::FOP_NONE;
        if (req_reg.action == rlc_pkg::ACT_ACQUIRE)
        begin
            dec_rs = 4'd0;
            priority if (!req_reg.quota_enabled && !req_reg.force_req)
            begin
                dec_status = rlc_pkg::ST_DISABLED;
            end
            else if (!req_reg.quota_file_open)
            begin
                dec_status = rlc_pkg::ST_FAULT;
            end
            else if (hit_reg)
            begin
                dec_rs = tgt_w[3:0];
                priority if (fl.locked)
                begin
                    dec_op     = rlc_pkg::SOP_SET_WANT;
                    dec_status = rlc_pkg::ST_BUSY;
                end
                else if (fl.refs == rlc_pkg::REFS_MAX)
                begin
                    dec_status = rlc_pkg::ST_FAULT;
                end
                else
                begin
                    dec_op     = rlc_pkg::SOP_HIT;
                    dec_status = rlc_pkg::ST_HIT;
                    dec_rem    = (fl.refs == 8'd0);
                end
            end
            else if (cnt_reg == '0)
            begin
                dec_status = rlc_pkg::ST_FULL;
            end
            else
            begin
                dec_rs = tgt_w[3:0];
                if (fl.refs != 8'd0 || fl.locked || fl.want || fl.modified)
                begin
                    dec_status = rlc_pkg::ST_FAULT;
                end
                else
                begin
                    dec_op     = rlc_pkg::SOP_ALLOC;
                    dec_rem    = 1'b1;
                    dec_status = req_reg.record_in_file ? rlc_pkg::ST_MISS_READ
                                                        : rlc_pkg::ST_MISS_ZERO;
                end
            end
        end
        else if (!slot_ok && req_reg.action <= rlc_pkg::ACT_MARK)
        begin
            dec_status = rlc_pkg::ST_FAULT;
        end
        else
        begin
            unique case (req_reg.action)
                rlc_pkg::ACT_RELEASE:
                begin
                    if (fl.refs != 8'd0 && fl.locked)
                    begin
                        dec_op     = rlc_pkg::SOP_RELEASE;
                        dec_wake   = fl.want;
                        dec_status = rlc_pkg::ST_RELEASED;
                        if (fl.refs == 8'd1)
                        begin
                            dec_rem = 1'b1;
                            dec_ins = rlc_pkg::FOP_INS_TAIL;
                        end
                    end
                end
                rlc_pkg::ACT_WRITEBACK:
                begin
                    if (fl.valid && req_reg.quota_file_open && fl.locked && fl.modified)
                    begin
                        dec_op     = rlc_pkg::SOP_WRITEBACK;
                        dec_status = rlc_pkg::ST_WRITEBACK;
                    end
                end
                rlc_pkg::ACT_INVAL:
                begin
                    if (fl.refs == 8'd0 && !fl.modified && !fl.want)
                    begin
                        dec_op     = rlc_pkg::SOP_INVAL;
                        dec_status = rlc_pkg::ST_INVAL;
                        dec_rem    = 1'b1;
                        dec_ins    = rlc_pkg::FOP_INS_HEAD;
                    end
                end
                rlc_pkg::ACT_LOADFAIL:
                begin
                    if (fl.locked && fl.refs == 8'd1)
                    begin
                        dec_op     = rlc_pkg::SOP_LOADFAIL;
                        dec_wake   = fl.want;
                        dec_status = rlc_pkg::ST_LOADFAIL;
                        dec_rem    = 1'b1;
                        dec_ins    = rlc_pkg::FOP_INS_HEAD;
                    end
                end
                rlc_pkg::ACT_MARK:
                begin
                    if (fl.locked)
                    begin
                        dec_op     = rlc_pkg::SOP_MARK;
                        dec_status = rlc_pkg::ST_MARKED;
                    end
                end
                default:
                begin
                    dec_rs = 4'd0;
                end
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rlc_pkg::S_IDLE:   if (req_acc) state_next = rlc_pkg::S_SEARCH;
            rlc_pkg::S_SEARCH: state_next = rlc_pkg::S_EXEC;
            rlc_pkg::S_EXEC:   state_next = dec_rem ? rlc_pkg::S_FREM : rlc_pkg::S_RESP;
            rlc_pkg::S_FREM:
            begin
                if (ins_reg != rlc_pkg::FOP_NONE && cnt_next != CW'(NUM_ENTRIES))
                begin
                    state_next = rlc_pkg::S_FINS;
                end
                else
                begin
                    state_next = rlc_pkg::S_RESP;
                end
            end
            rlc_pkg::S_FINS:   state_next = rlc_pkg::S_RESP;
            rlc_pkg::S_RESP:   if (!rsp_stall) state_next = rlc_pkg::S_IDLE;
            default:           state_next = rlc_pkg::S_IDLE;
        endcase
    end

    // outputs and commands
    always_comb
    begin
        req_stall    = (state_reg != rlc_pkg::S_IDLE);
        rsp_valid    = (state_reg == rlc_pkg::S_RESP);
        rsp          = rsp_reg;
        cmd.op       = (state_reg == rlc_pkg::S_EXEC) ? dec_op : rlc_pkg::SOP_NONE;
        cmd.user_id  = req_reg.user_id;
        cmd.mount_id = req_reg.mount_id;
        unique case (state_reg)
            rlc_pkg::S_FREM: fop = rlc_pkg::FOP_REMOVE;
            rlc_pkg::S_FINS: fop = ins_reg;
            default:         fop = rlc_pkg::FOP_NONE;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        unique case (state_reg)
            rlc_pkg::S_FREM: if (seen[NUM_ENTRIES]) cnt_next = cnt_reg - CW'(1);
            rlc_pkg::S_FINS: cnt_next = cnt_reg + CW'(1);
            default:         ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rlc_pkg::S_IDLE;
            cnt_reg   <= CW'(NUM_ENTRIES);
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            req_reg <= req;
        end
        if (state_reg == rlc_pkg::S_SEARCH)
        begin
            hit_reg     <= any_hit;
            hit_idx_reg <= first_idx;
        end
        if (state_reg == rlc_pkg::S_EXEC)
        begin
            rsp_reg.status       <= dec_status;
            rsp_reg.result_slot  <= dec_rs;
            rsp_reg.wake_waiters <= dec_wake;
            fs_reg               <= tgt;
            rem_reg              <= dec_rem;
            ins_reg              <= dec_ins;
        end
    end

    `RLC_ASSERT_IMPL(a_count_bound, 1'b1, cnt_reg <= CW'(NUM_ENTRIES))
    `RLC_ASSERT_NEXT(a_accept_search, req_acc, state_reg == rlc_pkg::S_SEARCH)
    `RLC_ASSERT_IMPL(a_ins_room, state_reg == rlc_pkg::S_FINS, cnt_reg != CW'(NUM_ENTRIES))
    `RLC_ASSERT_IMPL(a_rem_flag, state_reg == rlc_pkg::S_FREM, rem_reg)

endmodule

// ===== tb/refcounted_lru_tag_cache_core_tb.sv =====
// testbench for the tag cache directory: random and directed requests checked against a predictor
`timescale 1ns / 1ps
module refcounted_lru_tag_cache_core_tb;

    localparam int NSLOT = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    rlc_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rlc_pkg::rsp_t rsp;

    refcounted_lru_tag_cache_core #(.NUM_ENTRIES(NSLOT)) dut (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_stall(req_stall),
        .req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    always #2 clk = ~clk;

    // directory state mirror
    logic        dir_valid [NSLOT];
    logic [15:0] dir_user [NSLOT];
    logic [7:0]  dir_mount [NSLOT];
    logic [7:0]  dir_refs [NSLOT];
    logic        dir_locked [NSLOT];
    logic        dir_want [NSLOT];
    logic        dir_mod [NSLOT];
    int          lru_list [$];

    rlc_pkg::req_t pending_reqs [$];
    rlc_pkg::rsp_t expected_rsps [$];
    int   mismatches = 0;
    int   n_sent = 0;
    int   n_rcvd = 0;
    int   idle_cycles = 0;
    bit   timed_out = 0;
    bit   hold_sender = 0;
    bit   req_taken = 0;
    int   send_gap = 0;
    int   recv_gap = 0;
    int   status_seen [16];

    function automatic void lru_drop(input int s);
        for (int i = 0; i < lru_list.size(); i++)
        begin
            if (lru_list[i] == s)
            begin
                lru_list.delete(i);
                return;
            end
        end
    endfunction

    function automatic rlc_pkg::rsp_t predict_dir(input rlc_pkg::req_t r);
        rlc_pkg::rsp_t o;
        int s;
        bit found;
        o = '0;
        o.status = rlc_pkg::ST_FAULT;
        s = int'(r.slot);
        found = 0;
        case (r.action)
            rlc_pkg::ACT_ACQUIRE:
            begin
                if (!r.quota_enabled && !r.force_req)
                    o.status = rlc_pkg::ST_DISABLED;
                else if (!r.quota_file_open)
                    o.status = rlc_pkg::ST_FAULT;
                else
                begin
                    for (int i = 0; i < NSLOT && !found; i++)
                    begin
                        if (dir_valid[i] && dir_user[i] == r.user_id && dir_mount[i] == r.mount_id)
                        begin
                            found = 1;
                            o.result_slot = 4'(i);
                            if (dir_locked[i])
                            begin
                                dir_want[i] = 1'b1;
                                o.status = rlc_pkg::ST_BUSY;
                            end
                            else if (dir_refs[i] == rlc_pkg::REFS_MAX)
                                o.status = rlc_pkg::ST_FAULT;
                            else
                            begin
                                dir_locked[i] = 1'b1;
                                if (dir_refs[i] == 8'd0)
                                    lru_drop(i);
                                dir_refs[i]++;
                                o.status = rlc_pkg::ST_HIT;
                            end
                        end
                    end
                    if (!found)
                    begin
                        if (lru_list.size() == 0)
                            o.status = rlc_pkg::ST_FULL;
                        else
                        begin
                            s = lru_list[0];
                            o.result_slot = 4'(s);
                            if (dir_refs[s] != 8'd0 || dir_locked[s] || dir_want[s] || dir_mod[s])
                                o.status = rlc_pkg::ST_FAULT;
                            else
                            begin
                                lru_drop(s);
                                dir_valid[s] = 1'b1;
                                dir_user[s] = r.user_id;
                                dir_mount[s] = r.mount_id;
                                dir_locked[s] = 1'b1;
                                dir_refs[s] = 8'd1;
                                o.status = r.record_in_file ? rlc_pkg::ST_MISS_READ
                                                            : rlc_pkg::ST_MISS_ZERO;
                            end
                        end
                    end
                end
            end
            rlc_pkg::ACT_RELEASE:
            begin
                o.result_slot = 4'(s);
                if (dir_refs[s] != 8'd0 && dir_locked[s])
                begin
                    o.wake_waiters = dir_want[s];
                    dir_locked[s] = 1'b0;
                    dir_want[s] = 1'b0;
                    dir_refs[s]--;
                    if (dir_refs[s] == 8'd0)
                    begin
                        dir_mod[s] = 1'b0;
                        lru_drop(s);
                        lru_list.push_back(s);
                    end
                    o.status = rlc_pkg::ST_RELEASED;
                end
            end
            rlc_pkg::ACT_WRITEBACK:
            begin
                o.result_slot = 4'(s);
                if (dir_valid[s] && r.quota_file_open && dir_locked[s] && dir_mod[s])
                begin
                    dir_mod[s] = 1'b0;
                    o.status = rlc_pkg::ST_WRITEBACK;
                end
            end
            rlc_pkg::ACT_INVAL:
            begin
                o.result_slot = 4'(s);
                if (dir_refs[s] == 8'd0 && !dir_mod[s] && !dir_want[s])
                begin
                    dir_locked[s] = 1'b0;
                    dir_valid[s] = 1'b0;
                    lru_drop(s);
                    lru_list.push_front(s);
                    o.status = rlc_pkg::ST_INVAL;
                end
            end
            rlc_pkg::ACT_LOADFAIL:
            begin
                o.result_slot = 4'(s);
                if (dir_locked[s] && dir_refs[s] == 8'd1)
                begin
                    dir_valid[s] = 1'b0;
                    dir_refs[s] = 8'd0;
                    dir_mod[s] = 1'b0;
                    o.wake_waiters = dir_want[s];
                    dir_locked[s] = 1'b0;
                    dir_want[s] = 1'b0;
                    lru_drop(s);
                    lru_list.push_front(s);
                    o.status = rlc_pkg::ST_LOADFAIL;
                end
            end
            rlc_pkg::ACT_MARK:
            begin
                o.result_slot = 4'(s);
                if (dir_locked[s])
                begin
                    dir_mod[s] = 1'b1;
                    o.status = rlc_pkg::ST_MARKED;
                end
            end
            default: o.status = rlc_pkg::ST_FAULT;
        endcase
        return o;
    endfunction

    function automatic rlc_pkg::req_t make_req(input logic [2:0] act, input logic [15:0] u,
                                               input logic [7:0] m, input logic [3:0] s);
        rlc_pkg::req_t r;
        r = '0;
        r.action = act;
        r.user_id = u;
        r.mount_id = m;
        r.slot = s;
        r.force_req = 1'b1;
        r.quota_enabled = 1'b1;
        r.quota_file_open = 1'b1;
        r.record_in_file = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        else if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_taken)
            begin
                req_valid <= 1'b0;
                send_gap <= pick_gap();
            end
            else if (!req_valid)
            begin
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
                else if (pending_reqs.size() != 0 && !hold_sender)
                begin
                    req <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
            end
            if (recv_gap > 0)
            begin
                rsp_stall <= 1'b1;
                recv_gap <= recv_gap - 1;
            end
            else
            begin
                rsp_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0)
                    recv_gap <= pick_gap();
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_taken <= req_valid && !req_stall;
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (req_valid && !req_stall)
            begin
                expected_rsps.push_back(predict_dir(req));
                n_sent <= n_sent + 1;
            end
            if (rsp_valid && !rsp_stall)
            begin
                rlc_pkg::rsp_t want_rsp;
                n_rcvd <= n_rcvd + 1;
                status_seen[rsp.status]++;
                if (expected_rsps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: status %0d slot %0d wake %0b",
                                 rsp.status, rsp.result_slot, rsp.wake_waiters);
                end
                else
                begin
                    want_rsp = expected_rsps.pop_front();
                    if (rsp.status !== want_rsp.status || rsp.result_slot !== want_rsp.result_slot ||
                        rsp.wake_waiters !== want_rsp.wake_waiters)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp status %0d slot %0d wake %0b, got %0d %0d %0b",
                                     want_rsp.status, want_rsp.result_slot, want_rsp.wake_waiters,
                                     rsp.status, rsp.result_slot, rsp.wake_waiters);
                    end
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_random(input int count);
        rlc_pkg::req_t r;
        int p;
        for (int k = 0; k < count; k++)
        begin
            r = make_req(rlc_pkg::ACT_ACQUIRE, 16'($urandom_range(0, 5)),
                         8'($urandom_range(0, 2)), 4'($urandom_range(0, 15)));
            if ($urandom_range(0, 9) == 0)
            begin
                r.user_id = 16'($urandom);
                r.mount_id = 8'($urandom);
            end
            p = $urandom_range(0, 99);
            if (p < 35)
                r.action = rlc_pkg::ACT_ACQUIRE;
            else if (p < 65)
                r.action = rlc_pkg::ACT_RELEASE;
            else if (p < 73)
                r.action = rlc_pkg::ACT_WRITEBACK;
            else if (p < 81)
                r.action = rlc_pkg::ACT_INVAL;
            else if (p < 87)
                r.action = rlc_pkg::ACT_LOADFAIL;
            else if (p < 96)
                r.action = rlc_pkg::ACT_MARK;
            else
                r.action = 3'($urandom_range(6, 7));
            if ($urandom_range(0, 9) == 0)
            begin
                r.force_req = 1'($urandom_range(0, 1));
                r.quota_enabled = 1'($urandom_range(0, 1));
            end
            if ($urandom_range(0, 14) == 0)
                r.quota_file_open = 1'b0;
            pending_reqs.push_back(r);
        end
    endtask

    initial
    begin
        rlc_pkg::req_t r;
        for (int i = 0; i < NSLOT; i++)
        begin
            dir_valid[i] = 1'b0;
            dir_user[i] = '0;
            dir_mount[i] = '0;
            dir_refs[i] = 8'd0;
            dir_locked[i] = 1'b0;
            dir_want[i] = 1'b0;
            dir_mod[i] = 1'b0;
            lru_list.push_back(NSLOT - 1 - i);
        end
        for (int i = 0; i < 16; i++)
            status_seen[i] = 0;

        // directed: field extremes, every action, special cases
        r = make_req(rlc_pkg::ACT_ACQUIRE, 16'hFFFF, 8'hFF, 4'hF);
        r.force_req = 1'b0; r.quota_enabled = 1'b0;
        pending_reqs.push_back(r);
        r = make_req(rlc_pkg::ACT_ACQUIRE, 16'hFFFF, 8'hFF, 4'hF);
        r.quota_file_open = 1'b0;
        pending_reqs.push_back(r);
        r = make_req(rlc_pkg::ACT_ACQUIRE, 16'hFFFF, 8'hFF, 4'hF);
        r.force_req = 1'b0; r.record_in_file = 1'b1;
        pending_reqs.push_back(r);
        r = make_req(rlc_pkg::ACT_ACQUIRE, 16'h0000, 8'h00, 4'h0);
        r.quota_enabled = 1'b0; r.record_in_file = 1'b0;
        pending_reqs.push_back(r);
        pending_reqs.push_back(make_req(rlc_pkg::ACT_ACQUIRE, 16'hFFFF, 8'hFF, 4'h0));
        pending_reqs.push_back(make_req(rlc_pkg::ACT_MARK, 16'h0, 8'h0, 4'hF));
        pending_reqs.push_back(make_req(rlc_pkg::ACT_WRITEBACK, 16'h0, 8'h0, 4'hF));
        pending_reqs.push_back(make_req(rlc_pkg::ACT_WRITEBACK, 16'h0, 8'h0, 4'hF));
        pending_reqs.push_back(make_req(rlc_pkg::ACT_INVAL, 16'h0, 8'h0, 4'hF));
        pending_reqs.push_back(make_req(rlc_pkg::ACT_RELEASE, 16'h0, 8'h0, 4'hF));
        pending_reqs.push_back(make_req(rlc_pkg::ACT_ACQUIRE, 16'hFFFF, 8'hFF, 4'h0));
        pending_reqs.push_back(make_req(rlc_pkg::ACT_RELEASE, 16'h0, 8'h0, 4'hF));
        pending_reqs.push_back(make_req(rlc_pkg::ACT_RELEASE, 16'h0, 8'h0, 4'hF));
        pending_reqs.push_back(make_req(rlc_pkg::ACT_MARK, 16'h0, 8'h0, 4'hE));
        pending_reqs.push_back(make_req(rlc_pkg::ACT_LOADFAIL, 16'h0, 8'h0, 4'hE));
        pending_reqs.push_back(make_req(rlc_pkg::ACT_INVAL, 16'h0, 8'h0, 4'hF));
        pending_reqs.push_back(make_req(rlc_pkg::ACT_RELEASE, 16'h0, 8'h0, 4'hE));
        pending_reqs.push_back(make_req(rlc_pkg::ACT_LOADFAIL, 16'h0, 8'h0, 4'hE));
        r = make_req(3'd6, 16'h0, 8'h0, 4'h0);
        pending_reqs.push_back(r);
        r = make_req(3'd7, 16'hFFFF, 8'hFF, 4'hF);
        pending_reqs.push_back(r);
        // fill the table to reach the full case
        for (int i = 0; i < 17; i++)
            pending_reqs.push_back(make_req(rlc_pkg::ACT_ACQUIRE, 16'(256 + i), 8'h7, 4'h0));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait_drained();
        // free the full table again
        for (int i = 0; i < NSLOT; i++)
            pending_reqs.push_back(make_req(rlc_pkg::ACT_RELEASE, 16'h0, 8'h0, 4'(i)));
        add_random(250);
        wait_drained();
        // sender holds off until every response is in
        add_random(50);
        repeat (30) @(posedge clk);
        hold_sender = 1;
        while (req_valid || expected_rsps.size() != 0)
            @(posedge clk);
        hold_sender = 0;
        wait_drained();

        add_random(250);
        wait_drained();
        repeat (20) @(posedge clk);

        $display("sent %0d requests, %0d responses; hits %0d misses %0d busy %0d full %0d",
                 n_sent, n_rcvd, status_seen[rlc_pkg::ST_HIT],
                 status_seen[rlc_pkg::ST_MISS_READ] + status_seen[rlc_pkg::ST_MISS_ZERO],
                 status_seen[rlc_pkg::ST_BUSY], status_seen[rlc_pkg::ST_FULL]);
        $display("releases %0d faults %0d, %0d mismatches", status_seen[rlc_pkg::ST_RELEASED],
                 status_seen[rlc_pkg::ST_FAULT], mismatches);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("refcounted_lru_tag_cache_core_tb OK");
        else
            $display("refcounted_lru_tag_cache_core_tb NOT OK");
        $finish;
    end

    // watchdog
    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1;
            $display("refcounted_lru_tag_cache_core_tb NOT OK");
            $finish;
        end
    end

endmodule
